FILE: rtl/core/wbac_pkg.sv
// Package for the wheel burst arrow classifier.
// Holds the mode, result and action codes, the state struct and the field widths.
// Depends on nothing; every module in rtl/core imports it.
package wbac_pkg;

    // Field widths.
    localparam int TimeW   = 32;
    localparam int ThreshW = 16;
    localparam int RemainW = 17;
    localparam int ActionW = 2;
    localparam int CodeW   = 3;

    // Reset value of the burst threshold in milliseconds.
    localparam logic [ThreshW-1:0] ThreshReset = 16'd20;

    // Input beat kinds, carried in tuser.
    localparam logic [ActionW-1:0] ACT_ARROW = 2'd0;
    localparam logic [ActionW-1:0] ACT_TICK  = 2'd1;
    localparam logic [ActionW-1:0] ACT_FLUSH = 2'd2;

    // Classifier mode, one-hot.
    typedef enum logic [2:0] {
        MODE_IDLE      = 3'b001,
        MODE_WAITING   = 3'b010,
        MODE_ABSORBING = 3'b100
    } mode_t;

    // Result codes.
    typedef enum logic [CodeW-1:0] {
        RES_NONE        = 3'd0,
        RES_ARROW_UP    = 3'd1,
        RES_ARROW_DOWN  = 3'd2,
        RES_SCROLL_UP   = 3'd3,
        RES_SCROLL_DOWN = 3'd4,
        RES_ABSORBED    = 3'd5
    } res_t;

    // Classifier state carried between beats.
    typedef struct packed {
        mode_t              mode;
        logic               pend_down;
        logic [TimeW-1:0]   timer_start;
    } cls_state_t;

    // Remaining time reported while idle: -1.
    localparam logic signed [RemainW-1:0] RemainIdle = -17'sd1;

endpackage

FILE: rtl/core/wbac_step.sv
// Next-state and result logic of the wheel burst arrow classifier for one beat.
// Purely combinational; uses the types and codes of wbac_pkg.
module wbac_step (
    input  wbac_pkg::cls_state_t                   state_cur,
    input  logic [wbac_pkg::ActionW-1:0]           action,
    input  logic                                   arrow_down,
    input  logic [wbac_pkg::TimeW-1:0]             time_ms,
    input  logic [wbac_pkg::ThreshW-1:0]           threshold,
    output wbac_pkg::cls_state_t                   state_next,
    output wbac_pkg::res_t                         result_code,
    output logic signed [wbac_pkg::RemainW-1:0]    remaining_ms
);
    import wbac_pkg::*;

    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] elapsed_after;
    logic [TimeW-1:0] thresh_wide;
    logic             in_window;
    logic             restart;
    mode_t            mode_cur;
    res_t             arrow_res;
    res_t             scroll_res;

    // Elapsed time since the timer started, modulo 2^32.
    assign thresh_wide = {{(TimeW-ThreshW){1'b0}}, threshold};
    assign elapsed     = time_ms - state_cur.timer_start;
    assign in_window   = (elapsed <= thresh_wide);
    assign arrow_res   = state_cur.pend_down ? RES_ARROW_DOWN : RES_ARROW_UP;
    assign scroll_res  = state_cur.pend_down ? RES_SCROLL_DOWN : RES_SCROLL_UP;

    // Any mode code that is not a member is treated as idle.
    always_comb begin
        unique case (state_cur.mode)
            MODE_IDLE:      mode_cur = MODE_IDLE;
            MODE_WAITING:   mode_cur = MODE_WAITING;
            MODE_ABSORBING: mode_cur = MODE_ABSORBING;
            default:        mode_cur = MODE_IDLE;
        endcase
    end

    // Mode transitions and result selection.
    always_comb begin
        state_next      = state_cur;
        state_next.mode = mode_cur;
        result_code     = RES_NONE;
        restart         = 1'b0;
        case (action)
            ACT_ARROW: begin
                restart = 1'b1;
                unique case (mode_cur)
                    MODE_WAITING: begin
                        if (in_window) begin
                            result_code     = scroll_res;
                            state_next.mode = MODE_ABSORBING;
                        end else begin
                            result_code          = arrow_res;
                            state_next.pend_down = arrow_down;
                        end
                    end
                    MODE_ABSORBING: begin
                        if (in_window) begin
                            result_code = RES_ABSORBED;
                        end else begin
                            state_next.mode      = MODE_WAITING;
                            state_next.pend_down = arrow_down;
                        end
                    end
                    default: begin
                        state_next.mode      = MODE_WAITING;
                        state_next.pend_down = arrow_down;
                    end
                endcase
            end
            ACT_TICK: begin
                if ((mode_cur != MODE_IDLE) && !in_window) begin
                    if (mode_cur == MODE_WAITING) begin
                        result_code = arrow_res;
                    end
                    state_next.mode = MODE_IDLE;
                end
            end
            ACT_FLUSH: begin
                if (mode_cur == MODE_WAITING) begin
                    result_code = arrow_res;
                end
                state_next.mode = MODE_IDLE;
            end
            default: begin
                // Unused action: no operation.
            end
        endcase
        if (restart) begin
            state_next.timer_start = time_ms;
        end
    end

    // Time left after this beat; a restarted timer has zero elapsed time.
    assign elapsed_after = restart ? '0 : elapsed;

    always_comb begin
        if (state_next.mode == MODE_IDLE) begin
            remaining_ms = RemainIdle;
        end else if (elapsed_after >= thresh_wide) begin
            remaining_ms = '0;
        end else begin
            remaining_ms = {1'b0, threshold - elapsed_after[ThreshW-1:0]};
        end
    end

endmodule

FILE: rtl/core/wheel_burst_arrow_classifier.sv
// Top level of the wheel burst arrow classifier: input register, state, result register.
// Instantiates wbac_step and imports wbac_pkg.
//
//  channel | dir | tdata (low bit up)                        | tuser
//  s_      | in  | arrow_down[0], time_ms[32:1], zeros[39:33] | action[1:0]
//  m_      | out | result_code[2:0], remaining_ms[19:3]       | -
//  cfg_    | in  | gap_limit_ms[15:0], written on we          | -
//
// Each beat passes through the input register; the step logic then updates the state
// and the result register at the same edge.
// One beat is accepted every cycle as long as the result side keeps taking beats.
// A stalled result holds the result register and then the input register.
// aresetn clears the valid bits, the mode and timer and loads a threshold of 20.
module wheel_burst_arrow_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // arrow_down, time_ms
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // result_code, remaining_ms
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import wbac_pkg::*;

    logic                       in_valid_reg;
    logic [ActionW-1:0]         in_action_reg;
    logic                       in_dir_reg;
    logic [TimeW-1:0]           in_time_reg;
    logic                       out_valid_reg;
    res_t                       out_code_reg;
    logic signed [RemainW-1:0]  out_remain_reg;
    logic [ThreshW-1:0]         thresh_reg;
    cls_state_t                 state_reg;
    cls_state_t                 state_next;
    res_t                       code_next;
    logic signed [RemainW-1:0]  remain_next;
    logic                       advance;

    // Pipeline flow control.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_dir_reg    <= s_tdata[0];
            in_time_reg   <= s_tdata[TimeW:1];
        end
    end

    // Threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= ThreshReset;
        end else if (cfg_we) begin
            thresh_reg <= cfg_wdata;
        end
    end

    wbac_step u_step (
        .state_cur    (state_reg),
        .action       (in_action_reg),
        .arrow_down   (in_dir_reg),
        .time_ms      (in_time_reg),
        .threshold    (thresh_reg),
        .state_next   (state_next),
        .result_code  (code_next),
        .remaining_ms (remain_next)
    );

    // Classifier state, updated once per beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode        <= MODE_IDLE;
            state_reg.pend_down   <= 1'b0;
            state_reg.timer_start <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_code_reg   <= code_next;
            out_remain_reg <= remain_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_remain_reg, out_code_reg};

    // The input side only stalls behind a held result.
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (out_valid_reg && !m_tready))
        else $error("input stalled without a held result");

    // A fresh result reports -1 exactly when the new mode is idle.
    a_idle_remain: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(advance) |-> ((state_reg.mode == MODE_IDLE) == (out_remain_reg == RemainIdle)))
        else $error("remaining time does not match mode");

    // An arrow beat always leaves the classifier out of idle.
    a_arrow_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_action_reg == ACT_ARROW)) |=> (state_reg.mode != MODE_IDLE))
        else $error("arrow left the classifier idle");

    // An absorbed result leaves the classifier absorbing.
    a_absorb_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(advance) && (out_code_reg == RES_ABSORBED)) |->
            (state_reg.mode == MODE_ABSORBING))
        else $error("absorbed result outside absorbing mode");

endmodule

FILE: bench/wbac_checker.sv
// Checker for the wheel burst arrow classifier: watches the input, result and threshold ports,
// predicts every result beat from its own copy of the classifier state and compares.
// Depends on wbac_pkg for the field widths, the mode and result enums and the action codes.
module wbac_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // arrow_down, time_ms
    input  logic [1:0]  s_tuser,   // action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // result_code, remaining_ms
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          verdicts_due
);
    import wbac_pkg::*;

    typedef struct packed {
        res_t                        code;
        logic signed [RemainW-1:0]   remain;
    } verdict_t;

    // Predicted result beats, oldest first.
    verdict_t pending_verdicts[$];

    // Shadow copy of the classifier state and the threshold register.
    mode_t                mode_q;
    logic                 pend_down_q;
    logic [TimeW-1:0]     timer_start_q;
    logic [ThreshW-1:0]   thresh_q;

    // Steps the shadow state by one input beat and returns the result it causes.
    function automatic verdict_t classify_event(input logic [ActionW-1:0] action,
                                                input logic dir,
                                                input logic [TimeW-1:0] now);
        logic [TimeW-1:0] elapsed;
        logic             in_window;
        verdict_t         v;
        elapsed   = now - timer_start_q;
        in_window = elapsed <= TimeW'(thresh_q);
        v.code    = RES_NONE;
        case (action)
            ACT_ARROW: begin
                case (mode_q)
                    MODE_WAITING: begin
                        // A second arrow in time makes the held one a scroll.
                        if (in_window) begin
                            v.code = pend_down_q ? RES_SCROLL_DOWN : RES_SCROLL_UP;
                            mode_q = MODE_ABSORBING;
                        end else begin
                            v.code      = pend_down_q ? RES_ARROW_DOWN : RES_ARROW_UP;
                            pend_down_q = dir;
                        end
                    end
                    MODE_ABSORBING: begin
                        // In time the arrow is absorbed; too late for the running burst, a new one starts.
                        if (in_window) begin
                            v.code = RES_ABSORBED;
                        end else begin
                            mode_q      = MODE_WAITING;
                            pend_down_q = dir;
                        end
                    end
                    default: begin
                        mode_q      = MODE_WAITING;
                        pend_down_q = dir;
                    end
                endcase
                timer_start_q = now;
            end
            ACT_TICK: begin
                if (mode_q != MODE_IDLE && !in_window) begin
                    if (mode_q == MODE_WAITING) begin
                        v.code = pend_down_q ? RES_ARROW_DOWN : RES_ARROW_UP;
                    end
                    mode_q = MODE_IDLE;
                end
            end
            ACT_FLUSH: begin
                if (mode_q == MODE_WAITING) begin
                    v.code = pend_down_q ? RES_ARROW_DOWN : RES_ARROW_UP;
                end
                mode_q = MODE_IDLE;
            end
            default: begin
            end
        endcase

        // Time left is measured after the update, against this beat's timestamp.
        if (mode_q == MODE_IDLE) begin
            v.remain = RemainIdle;
        end else begin
            elapsed = now - timer_start_q;
            if (elapsed >= TimeW'(thresh_q)) begin
                v.remain = '0;
            end else begin
                v.remain = {1'b0, thresh_q - elapsed[ThreshW-1:0]};
            end
        end
        return v;
    endfunction

    // Result beats are checked before the new input beat is predicted.
    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            mode_q        = MODE_IDLE;
            pend_down_q   = 1'b0;
            timer_start_q = '0;
            thresh_q      = ThreshReset;
            pending_verdicts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with none expected, actual code %0d remaining %0d",
                             $time, m_tdata[2:0], $signed(m_tdata[19:3]));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_tdata[2:0] != want.code) begin
                        fail_count++;
                        $display("%0t: result_code expected %0d actual %0d",
                                 $time, want.code, m_tdata[2:0]);
                    end
                    if (m_tdata[19:3] != want.remain) begin
                        fail_count++;
                        $display("%0t: remaining_ms expected %0d actual %0d",
                                 $time, want.remain, $signed(m_tdata[19:3]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_verdicts.push_back(classify_event(s_tuser, s_tdata[0], s_tdata[32:1]));
            end
            if (cfg_we) begin
                thresh_q = cfg_wdata;
            end
        end
        verdicts_due = pending_verdicts.size();
    end

endmodule

FILE: bench/tb_wheel_burst_arrow_classifier.sv
// Testbench top for the wheel burst arrow classifier: clock, reset, input beats and the verdict.
// Depends on wbac_pkg, the classifier RTL and the wbac_checker module in this folder.
module tb_wheel_burst_arrow_classifier;
    import wbac_pkg::*;

    // Action code with no defined operation.
    localparam logic [ActionW-1:0] ACT_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 66;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // arrow_down, time_ms
    logic [1:0]  s_tuser;    // action
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // result_code, remaining_ms
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    int          fail_count;
    int          verdicts_due;
    int          cycle_count;
    int          idle_pct;
    int          stall_pct;
    logic [31:0] now_ms;
    logic [15:0] thresh;

    wheel_burst_arrow_classifier uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    wbac_checker verdict_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .verdicts_due (verdicts_due)
    );

    // Clock with a period of 10.
    always #5 aclk = ~aclk;

    // Result side stalls at random according to the current phase.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one beat, with random idle cycles first; called and left at a falling edge.
    task automatic send_beat(input logic [ActionW-1:0] act, input logic dir,
                             input logic [31:0] t);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {8'($urandom), $urandom};
            s_tuser  <= 2'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'b0, t, dir};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stops sending until every predicted result has been taken.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (verdicts_due != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        thresh     = value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One random beat: mostly arrows a short gap apart, so bursts form, plus ticks,
    // flushes, the spare action and gaps right at, past or behind the threshold.
    task automatic send_random_beat();
        int            pick;
        logic [ActionW-1:0] act;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            now_ms = now_ms + $urandom_range(0, thresh);
        end else if (pick < 75) begin
            now_ms = now_ms + thresh + $urandom_range(0, 3) - 1;
        end else if (pick < 92) begin
            now_ms = now_ms + $urandom_range(0, 3 * thresh + 100);
        end else begin
            now_ms = $urandom;
        end
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
            act = ACT_ARROW;
        end else if (pick < 82) begin
            act = ACT_TICK;
        end else if (pick < 94) begin
            act = ACT_FLUSH;
        end else begin
            act = ACT_SPARE;
        end
        send_beat(act, 1'($urandom), now_ms);
    endtask

    initial begin
        logic [15:0] phase_thresh [PHASES];
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b1;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        cycle_count = 0;
        idle_pct    = 0;
        stall_pct   = 0;
        thresh      = ThreshReset;
        phase_thresh = '{16'd0, 16'hFFFF, 16'd20, 16'($urandom), 16'd1,
                         16'($urandom_range(0, 200)), 16'd3, 16'($urandom)};

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed beats with the reset threshold of 20.
        send_beat(ACT_TICK,  1'b0, 32'd1000);        // tick while idle
        send_beat(ACT_FLUSH, 1'b1, 32'd1000);        // flush while idle
        send_beat(ACT_ARROW, 1'b0, 32'd1000);        // first arrow held
        send_beat(ACT_ARROW, 1'b1, 32'd1020);        // gap equal to threshold: scroll
        send_beat(ACT_ARROW, 1'b1, 32'd1040);        // absorbed
        send_beat(ACT_ARROW, 1'b0, 32'd1061);        // late while absorbing: new burst
        send_beat(ACT_TICK,  1'b1, 32'd1081);        // tick just in time, nothing
        send_beat(ACT_TICK,  1'b0, 32'd1082);        // tick after timeout releases arrow
        send_beat(ACT_ARROW, 1'b1, 32'd1100);
        send_beat(ACT_ARROW, 1'b0, 32'd1121);        // late while waiting: keyboard arrow
        send_beat(ACT_FLUSH, 1'b0, 32'd1125);        // flush releases the held arrow
        send_beat(ACT_ARROW, 1'b1, 32'd1130);
        send_beat(ACT_ARROW, 1'b1, 32'd1135);        // scroll down
        send_beat(ACT_FLUSH, 1'b0, 32'd1136);        // flush while absorbing
        send_beat(ACT_SPARE, 1'b1, 32'd1140);        // spare action while idle
        send_beat(ACT_ARROW, 1'b0, 32'hFFFF_FFF8);
        send_beat(ACT_ARROW, 1'b0, 32'h0000_0004);   // burst across the timestamp wrap
        send_beat(ACT_SPARE, 1'b0, 32'h0000_000A);   // spare action while absorbing
        send_beat(ACT_TICK,  1'b1, 32'h0000_0018);
        send_beat(ACT_TICK,  1'b0, 32'h0000_0100);   // timeout ends the burst
        send_beat(ACT_ARROW, 1'b1, 32'h0000_0200);
        send_beat(ACT_ARROW, 1'b0, 32'h0000_0100);   // time going back counts as expired
        send_beat(ACT_ARROW, 1'b1, 32'hFFFF_FFFF);
        send_beat(ACT_ARROW, 1'b0, 32'h0000_0000);
        send_beat(ACT_FLUSH, 1'b1, 32'h0000_0000);

        // Random phases, each with its own threshold and idle profile.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_threshold(phase_thresh[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            now_ms = (p % 3 == 1) ? 32'hFFFF_FFC0 - {16'b0, thresh} : $urandom;
            for (int i = 0; i < PHASE_BEATS; i++) begin
                send_random_beat();
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
